// ----- sv/fcfs_pkg.sv -----
package fcfs_pkg;

    typedef enum logic [2:0] {
        ST_UNUSED  = 3'd0,
        ST_NEW     = 3'd1,
        ST_READY   = 3'd2,
        ST_RUN     = 3'd3,
        ST_BLOCKED = 3'd4,
        ST_DONE    = 3'd5
    } entry_state_t;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_INTERRUPT = 2'd1,
        EV_ERROR     = 2'd2
    } tick_event_t;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic REG_BLOCK_TICKS  = 1'b0;
    localparam logic REG_MEMORY_SLOTS = 1'b1;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_SCAN = 2'd1,
        FSM_OUT  = 2'd2
    } fsm_state_t;

    // one table entry as it travels along the ring of cells
    typedef struct packed {
        entry_state_t st;
        logic [5:0]   needed;
        logic [5:0]   elapsed;
        logic [3:0]   age;
        logic [15:0]  arrival;
        logic [15:0]  response;
        logic         responded;
    } entry_t;

    // per-tick control handed from the sequencer to the head of the ring
    typedef struct packed {
        logic [3:0]  block_ticks;
        logic        admit_ok;
        logic        dispatch_ok;
        logic        is_cpu;
        logic [1:0]  ev;
        logic [15:0] clock_now;
    } tick_ctl_t;

    // what the head processing step reports back
    typedef struct packed {
        logic        admitted;
        logic        dispatched;
        logic        running;
        logic        freed;
        logic        done;
        logic        done_error;
        logic [15:0] arrival;
        logic [15:0] response;
        logic [5:0]  elapsed;
    } tick_rsp_t;

    function automatic entry_t fcfs_process(input entry_t e, input tick_ctl_t c,
                                            output tick_rsp_t r);
        entry_t     n;
        logic [3:0] a;
        logic [5:0] el;
        n = e;
        r = '0;
        a = e.age + 4'd1;
        if (e.st == ST_BLOCKED) begin
            n.age = a;
            if (a >= c.block_ticks) begin
                n.st  = ST_READY;
                n.age = 4'd0;
            end
        end
        if (c.admit_ok && n.st == ST_NEW) begin
            n.st       = ST_READY;
            n.arrival  = c.clock_now;
            r.admitted = 1'b1;
        end
        if (c.dispatch_ok && n.st == ST_READY) begin
            n.st         = ST_RUN;
            r.dispatched = 1'b1;
        end
        if (c.is_cpu || r.dispatched) begin
            r.running = 1'b1;
            if (!n.responded) begin
                n.response  = c.clock_now - n.arrival;
                n.responded = 1'b1;
            end
            el = n.elapsed + 6'd1;
            case (c.ev)
                EV_INTERRUPT: begin
                    n.st    = ST_BLOCKED;
                    n.age   = 4'd0;
                    r.freed = 1'b1;
                end
                EV_ERROR: begin
                    n.st         = ST_DONE;
                    r.freed      = 1'b1;
                    r.done       = 1'b1;
                    r.done_error = 1'b1;
                end
                default: begin
                    n.elapsed = el;
                    if (el >= n.needed) begin
                        n.st    = ST_DONE;
                        r.freed = 1'b1;
                        r.done  = 1'b1;
                    end
                end
            endcase
            r.arrival  = n.arrival;
            r.response = n.response;
            r.elapsed  = n.elapsed;
        end
        return n;
    endfunction

endpackage

// ----- sv/fcfs_cell.sv -----
// one slot of the rotating entry ring
module fcfs_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  fcfs_pkg::entry_t d,
    output fcfs_pkg::entry_t q
);
    fcfs_pkg::entry_t ent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
        end
        else if (shift)
        begin
            ent_reg <= d;
        end
    end

    assign q = ent_reg;
endmodule

// ----- sv/fcfs_process_scheduler.sv -----
// channel | direction | signals
// in      | in        | in_valid, in_stall(out), kind, service_time, tick_event
// out     | out       | out_valid, out_stall(in), running_* , add_accepted, done_*
// cfg     | in        | cfg_valid, cfg_ready(out), cfg_index, cfg_data
// an add or a tick rotates the entry ring once
// the result is offered in the next cycle; the next item is taken in the cycle after it leaves,
// so no new item is taken while one is in work or its result has not yet left
// reset is asynchronous, clears all entries to unused and the counters to zero
// in_stall is high while an item is in work or its result is offered and not yet taken
module fcfs_process_scheduler #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [5:0]  service_time,
    input  logic [1:0]  tick_event,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        running_valid,
    output logic [6:0]  running_index,
    output logic        add_accepted,
    output logic        done_valid,
    output logic [6:0]  done_index,
    output logic        done_error,
    output logic [15:0] done_arrival,
    output logic [15:0] done_finish,
    output logic [15:0] done_turnaround,
    output logic [15:0] done_response,
    output logic [15:0] done_wait,
    output logic [5:0]  done_service,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    fcfs_pkg::fsm_state_t state_reg, state_next;
    logic [3:0]  block_ticks_reg;
    logic [7:0]  memory_slots_reg;
    logic [CW-1:0] process_count_reg;
    logic [CW-1:0] occupied_reg;
    logic        cpu_busy_reg;
    logic [IW-1:0] cpu_index_reg;
    logic [15:0] clock_reg;
    logic [IW-1:0] pos_reg;
    logic [1:0]  ev_reg;

    logic        r_running_valid_reg, r_add_reg, r_done_valid_reg, r_done_error_reg;
    logic [6:0]  r_running_index_reg, r_done_index_reg;
    logic [15:0] r_arrival_reg, r_response_reg;
    logic [5:0]  r_service_reg;

    fcfs_pkg::entry_t cell_d [TABLE_DEPTH];
    fcfs_pkg::entry_t cell_q [TABLE_DEPTH];
    logic shift;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            fcfs_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (cell_d[g]),
                .q     (cell_q[g])
            );
            if (g < TABLE_DEPTH - 1)
            begin : g_link
                assign cell_d[g] = cell_q[g+1];
            end
        end
    endgenerate

    // on a tick, head cell 0 is processed and written back to the tail
    fcfs_pkg::tick_ctl_t ctl;
    fcfs_pkg::tick_rsp_t rsp;
    fcfs_pkg::entry_t    head_new;
    logic                in_table;
    logic                add_ok;
    logic [CW-1:0]       pos_ext;

    assign pos_ext  = CW'(pos_reg);
    assign in_table = pos_ext < process_count_reg;
    assign add_ok   = process_count_reg < CW'(TABLE_DEPTH);

    always_comb
    begin
        ctl.block_ticks = block_ticks_reg;
        // a finish earlier in this tick frees its slot only after admission
        ctl.admit_ok    = in_table
                          && ((32'(occupied_reg) + 32'(r_done_valid_reg))
                              < 32'(memory_slots_reg));
        // at most one dispatch per tick, and only if the cpu was free at its start
        ctl.dispatch_ok = in_table && !cpu_busy_reg && !r_running_valid_reg;
        ctl.is_cpu      = in_table && cpu_busy_reg && (cpu_index_reg == pos_reg);
        ctl.ev          = ev_reg;
        ctl.clock_now   = clock_reg;
        head_new        = fcfs_pkg::fcfs_process(cell_q[0], ctl, rsp);
        if (!in_table)
        begin
            head_new = cell_q[0];
        end
    end

    assign shift = state_reg == fcfs_pkg::FSM_SCAN;

    // adds rotate the ring too and drop the new entry in at its index
    logic accept_in;
    assign accept_in = in_valid && !in_stall;
    assign in_stall  = state_reg != fcfs_pkg::FSM_IDLE;
    assign cfg_ready = state_reg == fcfs_pkg::FSM_IDLE;

    logic is_add_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcfs_pkg::FSM_IDLE:
                if (accept_in) state_next = fcfs_pkg::FSM_SCAN;
            fcfs_pkg::FSM_SCAN:
                if (pos_reg == IW'(TABLE_DEPTH - 1)) state_next = fcfs_pkg::FSM_OUT;
            fcfs_pkg::FSM_OUT:
                if (!out_stall) state_next = fcfs_pkg::FSM_IDLE;
            default:
                state_next = fcfs_pkg::FSM_IDLE;
        endcase
    end

    logic [5:0] svc_reg;

    // for an add the ring rotates once and, if the table is not full, the entry at process_count is overwritten
    fcfs_pkg::entry_t add_entry;
    always_comb
    begin
        add_entry           = '0;
        add_entry.st        = fcfs_pkg::ST_NEW;
        add_entry.needed    = svc_reg;
    end

    fcfs_pkg::entry_t tail_in;
    always_comb
    begin
        if (is_add_reg)
        begin
            tail_in = (add_ok && pos_ext == process_count_reg) ? add_entry : cell_q[0];
        end
        else
        begin
            tail_in = head_new;
        end
    end

    assign cell_d[TABLE_DEPTH-1] = tail_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= fcfs_pkg::FSM_IDLE;
            block_ticks_reg     <= 4'd8;
            memory_slots_reg    <= 8'd5;
            process_count_reg   <= '0;
            occupied_reg        <= '0;
            cpu_busy_reg        <= 1'b0;
            cpu_index_reg       <= '0;
            clock_reg           <= '0;
            pos_reg             <= '0;
            ev_reg              <= fcfs_pkg::EV_NONE;
            is_add_reg          <= 1'b0;
            svc_reg             <= '0;
            r_running_valid_reg <= 1'b0;
            r_add_reg           <= 1'b0;
            r_done_valid_reg    <= 1'b0;
            r_done_error_reg    <= 1'b0;
            r_running_index_reg <= '0;
            r_done_index_reg    <= '0;
            r_arrival_reg       <= '0;
            r_response_reg      <= '0;
            r_service_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fcfs_pkg::REG_BLOCK_TICKS)
                    block_ticks_reg <= cfg_data[3:0];
                else
                    memory_slots_reg <= cfg_data;
            end
            if (accept_in)
            begin
                pos_reg             <= '0;
                ev_reg              <= tick_event;
                is_add_reg          <= (kind == fcfs_pkg::KIND_ADD);
                svc_reg             <= service_time;
                r_running_valid_reg <= 1'b0;
                r_add_reg           <= 1'b0;
                r_done_valid_reg    <= 1'b0;
                r_done_error_reg    <= 1'b0;
                r_running_index_reg <= '0;
                r_done_index_reg    <= '0;
                r_arrival_reg       <= '0;
                r_response_reg      <= '0;
                r_service_reg       <= '0;
            end
            if (state_reg == fcfs_pkg::FSM_SCAN)
            begin
                pos_reg <= pos_reg + IW'(1);
                if (is_add_reg)
                begin
                    if (pos_reg == IW'(TABLE_DEPTH - 1) && add_ok)
                    begin
                        process_count_reg <= process_count_reg + CW'(1);
                        r_add_reg         <= 1'b1;
                    end
                end
                else
                begin
                    if (rsp.admitted && !rsp.freed)
                        occupied_reg <= occupied_reg + CW'(1);
                    else if (rsp.freed && !rsp.admitted && occupied_reg != '0
                             && rsp.done)
                        occupied_reg <= occupied_reg - CW'(1);
                    else if (rsp.admitted && rsp.freed && !rsp.done)
                        occupied_reg <= occupied_reg + CW'(1);
                    if (rsp.dispatched)
                    begin
                        cpu_busy_reg  <= 1'b1;
                        cpu_index_reg <= pos_reg;
                    end
                    if (rsp.freed)
                        cpu_busy_reg <= 1'b0;
                    if (rsp.running)
                    begin
                        r_running_valid_reg <= 1'b1;
                        r_running_index_reg <= 7'(pos_reg);
                    end
                    if (rsp.done)
                    begin
                        r_done_valid_reg <= 1'b1;
                        r_done_index_reg <= 7'(pos_reg);
                        r_done_error_reg <= rsp.done_error;
                        r_arrival_reg    <= rsp.arrival;
                        r_response_reg   <= rsp.response;
                        r_service_reg    <= rsp.elapsed;
                    end
                    if (pos_reg == IW'(TABLE_DEPTH - 1))
                        clock_reg <= clock_reg + 16'd1;
                end
            end
        end
    end

    // after a tick the clock has already advanced when the result is offered
    logic [15:0] fin, tat;
    assign fin = clock_reg;
    assign tat = fin - r_arrival_reg;

    assign out_valid       = state_reg == fcfs_pkg::FSM_OUT;
    assign running_valid   = r_running_valid_reg;
    assign running_index   = r_running_index_reg;
    assign add_accepted    = r_add_reg;
    assign done_valid      = r_done_valid_reg;
    assign done_index      = r_done_index_reg;
    assign done_error      = r_done_error_reg;
    assign done_arrival    = r_arrival_reg;
    assign done_finish     = r_done_valid_reg ? fin : 16'd0;
    assign done_turnaround = r_done_valid_reg ? tat : 16'd0;
    assign done_response   = r_response_reg;
    assign done_wait       = r_done_valid_reg ? (tat - {10'd0, r_service_reg}) : 16'd0;
    assign done_service    = r_service_reg;
endmodule
